FILE: src/pidaw_pkg.sv
// Package for the PID controller with output clamp and anti-windup.
// Holds request and result payload types, divider status, widths and register indexes.
// No dependencies.
package pidaw_pkg;

	localparam int DATA_W     = 16;
	localparam int LIM_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W    = 33;
	localparam int MUL_B_W    = 18;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

	localparam int DIV_DVD_W  = 47;
	localparam int DIV_DVS_W  = 16;
	localparam int DIV_CNT_W  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd6;

	localparam logic signed [DATA_W-1:0] GAIN_P_RST    = 16'sd256;
	localparam logic signed [DATA_W-1:0] GAIN_D_RST    = 16'sd0;
	localparam logic signed [DATA_W-1:0] GAIN_I_RST    = 16'sd0;
	localparam logic        [DATA_W-1:0] STEP_TIME_RST = 16'd164;
	localparam logic signed [DATA_W-1:0] OUT_MIN_RST   = 16'sh8000;
	localparam logic signed [DATA_W-1:0] OUT_MAX_RST   = 16'sh7fff;
	localparam logic        [LIM_W-1:0]  INT_LIMIT_RST = 31'h7fffffff;

	typedef struct packed {
		logic signed [DATA_W-1:0] error_now;
		logic signed [DATA_W-1:0] error_before;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     clamped;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

FILE: src/pidaw_mul.sv
// Shared signed multiplier with registered product.
// Depends on pidaw_pkg for operand and product widths.
module pidaw_mul import pidaw_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

FILE: src/pidaw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pidaw_pkg for widths and the status struct.
module pidaw_div import pidaw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DVS_W-1:0] divisor,
	output logic [DIV_DVD_W-1:0] quotient,
	output div_status_t          status
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_DVD_W - 1);

	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DVS_W:0]   rem_sh;
	logic [DIV_DVS_W+1:0] diff;
	logic                 qbit;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit   = ~diff[DIV_DVS_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

FILE: src/pid_controller_antiwindup_unit.sv
// PID controller with output clamp and integral anti-windup, one axis.
// A new request is taken only in idle, once the previous one has been loaded into the output register.
// The time per request is set mostly by the bit-serial divider for the derivative term.
// The next request is taken while a finished result still waits in the output register.
// Reset: config registers take their defaults, stored integral clears, no clearing pass.
module pid_controller_antiwindup_unit import pidaw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_MUL_T,
		ST_INC,
		ST_PI,
		ST_WAIT,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;

	logic signed [DATA_W-1:0] gp_q, gd_q, gi_q, omin_q, omax_q;
	logic        [DATA_W-1:0] dt_q;
	logic        [LIM_W-1:0]  lim_q;

	logic signed [DATA_W-1:0] e_q, ep_q;
	logic signed [31:0]       p_q, num_q, integ_q, integral_q;
	logic signed [32:0]       pi_q;
	logic signed [48:0]       sum_q;
	result_t                  result_q;
	logic                     result_valid_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic                 div_start;
	logic [DIV_DVD_W-1:0] div_dividend;
	logic [DIV_DVD_W-1:0] div_quot;
	div_status_t          div_st;

	logic [DATA_W-1:0]        dt_eff;
	logic signed [DATA_W:0]   err_diff;
	logic [31:0]              num_mag;
	logic [33:0]              acc;
	logic signed [31:0]       integ_sat;
	logic [32:0]              integ_mag;
	logic signed [31:0]       integ_aw;
	logic [48:0]              pi_ext, quot_ext;
	logic signed [48:0]       hi_lim, lo_lim;
	logic                     sum_hi, sum_lo, out_load;

	pidaw_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pidaw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (dt_eff),
		.quotient (div_quot),
		.status   (div_st)
	);

	always_comb begin
		dt_eff   = (dt_q == '0) ? 16'd1 : dt_q;
		err_diff = {e_q[15], e_q} - {ep_q[15], ep_q};
		case (state_q)
			ST_MUL_D: begin
				mul_a = {{16{err_diff[16]}}, err_diff};
				mul_b = {{2{gd_q[15]}}, gd_q};
			end
			ST_MUL_I: begin
				mul_a = {{17{e_q[15]}}, e_q};
				mul_b = {{2{gi_q[15]}}, gi_q};
			end
			ST_MUL_T: begin
				mul_a = prod[MUL_A_W-1:0];
				mul_b = {2'b00, dt_eff};
			end
			default: begin
				mul_a = {{17{e_q[15]}}, e_q};
				mul_b = {{2{gp_q[15]}}, gp_q};
			end
		endcase

		num_mag      = num_q[31] ? (32'd0 - num_q) : num_q;
		div_start    = (state_q == ST_MUL_T);
		div_dividend = {num_mag[30:0], 16'd0};

		acc = {{2{integral_q[31]}}, integral_q} + prod[49:16];
		if (!acc[33] && acc[32:31] != 2'b00) begin
			integ_sat = 32'sh7fffffff;
		end else if (acc[33] && acc[32:31] != 2'b11) begin
			integ_sat = 32'sh80000000;
		end else begin
			integ_sat = acc[31:0];
		end

		integ_mag = integ_q[31] ? (33'd0 - {1'b1, integ_q}) : {1'b0, integ_q};
		if (integ_mag >= {2'b00, lim_q}) begin
			integ_aw = integ_q[31] ? (32'd0 - {1'b0, lim_q}) : {1'b0, lim_q};
		end else begin
			integ_aw = integ_q;
		end

		pi_ext   = {{16{pi_q[32]}}, pi_q};
		quot_ext = {2'b00, div_quot};
		hi_lim   = {{25{omax_q[15]}}, omax_q, 8'd0};
		lo_lim   = {{25{omin_q[15]}}, omin_q, 8'd0};
		sum_hi   = sum_q > hi_lim;
		sum_lo   = sum_q < lo_lim;
		out_load = (state_q == ST_OUT) && (!result_valid_q || result_ready);
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q   <= GAIN_P_RST;
			gd_q   <= GAIN_D_RST;
			gi_q   <= GAIN_I_RST;
			dt_q   <= STEP_TIME_RST;
			omin_q <= OUT_MIN_RST;
			omax_q <= OUT_MAX_RST;
			lim_q  <= INT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:    gp_q   <= cfg_data[DATA_W-1:0];
				REG_GAIN_D:    gd_q   <= cfg_data[DATA_W-1:0];
				REG_GAIN_I:    gi_q   <= cfg_data[DATA_W-1:0];
				REG_STEP_TIME: dt_q   <= cfg_data[DATA_W-1:0];
				REG_OUT_MIN:   omin_q <= cfg_data[DATA_W-1:0];
				REG_OUT_MAX:   omax_q <= cfg_data[DATA_W-1:0];
				REG_INT_LIMIT: lim_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (state_q == ST_PI) begin
			integral_q <= integ_aw;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					e_q  <= sample.error_now;
					ep_q <= sample.error_before;
				end
			end
			ST_MUL_D: p_q     <= prod[31:0];
			ST_MUL_I: num_q   <= prod[31:0];
			ST_INC:   integ_q <= integ_sat;
			ST_PI:    pi_q    <= {p_q[31], p_q} + {integ_q[31], integ_q};
			ST_SUM:   sum_q   <= num_q[31] ? (pi_ext - quot_ext) : (pi_ext + quot_ext);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (sample_valid) state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_T;
				ST_MUL_T: state_q <= ST_INC;
				ST_INC:   state_q <= ST_PI;
				ST_PI:    state_q <= ST_WAIT;
				ST_WAIT:  if (div_st.done) state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						result_valid_q <= 1'b1;
						if (sum_hi) begin
							result_q.drive   <= omax_q;
							result_q.clamped <= 1'b1;
						end else if (sum_lo) begin
							result_q.drive   <= omin_q;
							result_q.clamped <= 1'b1;
						end else begin
							result_q.drive   <= sum_q[23:8];
							result_q.clamped <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	logic [32:0] stored_mag;
	assign stored_mag = integral_q[31] ? (33'd0 - {1'b1, integral_q}) : {1'b0, integral_q};

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_st.done) |-> (state_q == ST_WAIT || state_q == ST_PI || state_q == ST_INC))
		else $error("divider finished outside its wait window");

	a_wait_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (div_st.busy || div_st.done))
		else $error("waiting on a divider that was never started");

	a_integral_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_PI) |-> (stored_mag <= {2'b00, lim_q}))
		else $error("stored integral exceeds its limit");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (!result_q.clamped || result_q.drive == $past(omax_q)
			|| result_q.drive == $past(omin_q)))
		else $error("clamped result is not a limit value");
`endif

endmodule
